// File: rtl/mptm_pkg.sv
package mptm_pkg;

    localparam int DEF_NODE_COUNT      = 512;
    localparam int DEF_MAX_PATTERN_LEN = 63;
    localparam int SYM_W               = 6;
    localparam int POS_W               = 32;

    typedef enum logic [1:0] {
        CMD_LOAD_TRANS = 2'd0,
        CMD_LOAD_NODE  = 2'd1,
        CMD_TEXT       = 2'd2,
        CMD_END        = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_SYM_START,
        ST_GOTO_RD,
        ST_GOTO_WAIT,
        ST_GOTO_CHK,
        ST_FAIL_WAIT,
        ST_FAIL_USE,
        ST_NODE_WAIT,
        ST_NODE_CHK,
        ST_OUT
    } state_t;

    // Classify a raw byte into a symbol code, 0 meaning separator
    function automatic logic [SYM_W-1:0] classify(input logic [7:0] b);
        logic [SYM_W-1:0] c;
        c = '0;
        if (b >= 8'h41 && b <= 8'h5A) c = SYM_W'(b - 8'h41 + 8'd1);
        else if (b >= 8'h61 && b <= 8'h7A) c = SYM_W'(b - 8'h61 + 8'd1);
        else if (b >= 8'h30 && b <= 8'h39) c = SYM_W'(b - 8'h30 + 8'd27);
        else if (b == 8'h2B) c = SYM_W'(37);
        else if (b == 8'h23) c = SYM_W'(38);
        else if (b == 8'h2E) c = SYM_W'(39);
        else if (b == 8'h26) c = SYM_W'(40);
        else if (b == 8'h2D) c = SYM_W'(41);
        return c;
    endfunction

endpackage

// File: rtl/mptm_ram.sv
module mptm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

// File: rtl/multi_pattern_token_matcher_top.sv
// Handling: a load, a separator byte or an end of text is done in the idle state; a text
// byte feeds up to two symbols, each walking the goto table and following failure links
// until a transition or the root is reached, or giving up after NODE_COUNT links.
// Throughput: one request at a time, paced by the single read port of each table;
// a result waiting on m_tready holds off the next request.
// Reset: aresetn low starts a clearing pass zeroing both tables.
module multi_pattern_token_matcher_top #(
    parameter int NODE_COUNT      = mptm_pkg::DEF_NODE_COUNT,
    parameter int MAX_PATTERN_LEN = mptm_pkg::DEF_MAX_PATTERN_LEN
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // command[1:0] node_index[10:2] symbol_code[16:11] next_node[25:17]
    // fail_node[34:26] pattern_id[43:35] category_id[51:44]
    // pattern_length[57:52] text_byte[65:58], zero fill to 72
    input  logic [71:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // match_start[31:0] match_end[63:32] found_pattern[72:64]
    // found_category[80:73], zero fill to 88
    output logic [87:0]  m_tdata
);
    import mptm_pkg::*;

    localparam int NW  = $clog2(NODE_COUNT);
    localparam int TAW = NW + SYM_W;
    localparam int TD  = NODE_COUNT * 64;
    localparam int RW  = NW + 9 + 8 + 6;

    // Input fields
    logic [1:0]  in_cmd;
    logic [8:0]  in_node, in_next, in_fail, in_pid;
    logic [5:0]  in_sym, in_len;
    logic [7:0]  in_cat, in_byte;
    assign in_cmd  = s_tdata[1:0];
    assign in_node = s_tdata[10:2];
    assign in_sym  = s_tdata[16:11];
    assign in_next = s_tdata[25:17];
    assign in_fail = s_tdata[34:26];
    assign in_pid  = s_tdata[43:35];
    assign in_cat  = s_tdata[51:44];
    assign in_len  = s_tdata[57:52];
    assign in_byte = s_tdata[65:58];

    state_t state_reg, state_next;

    logic [TAW-1:0]  clr_reg;
    logic [NW-1:0]   cur_reg, walk_reg;
    logic [SYM_W-1:0] sym_reg, sym2_reg;
    logic            second_reg;
    logic            pend_reg, started_reg;
    logic [POS_W-1:0] pos_reg;
    logic [63:0]     hist_reg;
    logic            hv_reg;
    logic [POS_W-1:0] hs_reg, he_reg;
    logic [8:0]      hp_reg;
    logic [7:0]      hc_reg;
    logic [12:0]     steps_reg;
    logic            ov_reg;
    logic [87:0]     od_reg;
    logic            sat_reg;

    // Table memories
    logic            t_we, n_we;
    logic [TAW-1:0]  t_wa, t_ra;
    logic [NW-1:0]   t_wd, t_rd, n_wa, n_ra;
    logic [RW-1:0]   n_wd, n_rd;
    logic            clearing;

    assign clearing = (state_reg == ST_CLEAR);

    mptm_ram #(.WIDTH(NW), .DEPTH(TD)) u_trans (
        .aclk(aclk), .we(t_we), .waddr(t_wa), .wdata(t_wd), .raddr(t_ra), .rdata(t_rd));
    mptm_ram #(.WIDTH(RW), .DEPTH(NODE_COUNT)) u_node (
        .aclk(aclk), .we(n_we), .waddr(n_wa), .wdata(n_wd), .raddr(n_ra), .rdata(n_rd));

    logic accept, load_ok;
    assign s_tready = (state_reg == ST_IDLE) && !ov_reg;
    assign accept   = s_tvalid && s_tready;
    assign load_ok  = ({{(32-9){1'b0}}, in_node} < NODE_COUNT);

    // Memory write side: clearing pass or loads
    always_comb begin
        t_we = 1'b0; n_we = 1'b0;
        t_wa = clr_reg; n_wa = clr_reg[NW-1:0];
        t_wd = '0; n_wd = '0;
        if (clearing) begin
            t_we = 1'b1;
            n_wa = clr_reg[TAW-1:SYM_W];
            n_we = (clr_reg[SYM_W-1:0] == '0);
        end else if (accept && load_ok && in_cmd == CMD_LOAD_TRANS) begin
            t_we = 1'b1;
            t_wa = {NW'(in_node), in_sym};
            t_wd = ({{(32-9){1'b0}}, in_next} < NODE_COUNT) ? NW'(in_next) : '0;
        end else if (accept && load_ok && in_cmd == CMD_LOAD_NODE) begin
            n_we = 1'b1;
            n_wa = NW'(in_node);
            n_wd = {(({{(32-9){1'b0}}, in_fail} < NODE_COUNT) ? NW'(in_fail) : {NW{1'b0}}),
                    in_pid, in_cat, in_len};
        end
    end

    // Decoded node record
    logic [NW-1:0] r_fail;
    logic [8:0]    r_pid;
    logic [7:0]    r_cat;
    logic [5:0]    r_len;
    assign {r_fail, r_pid, r_cat, r_len} = n_rd;

    logic [SYM_W-1:0] code;
    assign code = classify(in_byte);

    // Read addresses
    assign t_ra = {walk_reg, sym_reg};
    assign n_ra = walk_reg;

    // Left boundary check
    logic [32:0] endp;
    logic        left_ok, take;
    assign endp    = {1'b0, pos_reg} + 33'd1;
    assign left_ok = ({27'd0, r_len} == endp) ||
                     (({27'd0, r_len} < endp) && hist_reg[r_len]);
    assign take = (sym_reg != '0) && !sat_reg && (r_pid != '0) &&
                  ({26'd0, r_len} <= MAX_PATTERN_LEN) && left_ok;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:     if (clr_reg == TAW'(TD - 1)) state_next = ST_IDLE;
            ST_IDLE: begin
                if (accept && in_cmd == CMD_TEXT && code != '0)
                    state_next = ST_SYM_START;
                else if (accept && in_cmd == CMD_END && hv_reg)
                    state_next = ST_IDLE;
            end
            ST_SYM_START: state_next = ST_GOTO_WAIT;
            ST_GOTO_RD:   state_next = ST_GOTO_WAIT;
            ST_GOTO_WAIT: state_next = ST_GOTO_CHK;
            ST_GOTO_CHK: begin
                if (walk_reg == '0 || t_rd != '0)
                    state_next = ST_NODE_WAIT;
                else if ({19'd0, steps_reg} >= NODE_COUNT)
                    state_next = ST_GOTO_WAIT;   // give up, retry from the root
                else
                    state_next = ST_FAIL_WAIT;
            end
            ST_FAIL_WAIT: state_next = ST_FAIL_USE;
            ST_FAIL_USE:  state_next = ST_GOTO_WAIT;
            ST_NODE_WAIT: state_next = ST_NODE_CHK;
            ST_NODE_CHK:  state_next = ST_OUT;
            ST_OUT:       state_next = second_reg ? ST_SYM_START : ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            cur_reg     <= '0; walk_reg <= '0;
            pend_reg    <= 1'b0; started_reg <= 1'b0;
            pos_reg     <= '0; hist_reg <= '0;
            hv_reg      <= 1'b0; ov_reg <= 1'b0;
            second_reg  <= 1'b0; steps_reg <= '0;
            sym_reg <= '0; sym2_reg <= '0; sat_reg <= 1'b0;
            hs_reg <= '0; he_reg <= '0; hp_reg <= '0; hc_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (m_tvalid && m_tready) ov_reg <= 1'b0;
            case (state_reg)
                ST_CLEAR: clr_reg <= clr_reg + 1'b1;
                ST_IDLE: begin
                    if (accept && in_cmd == CMD_TEXT) begin
                        if (code == '0) begin
                            if (started_reg) pend_reg <= 1'b1;
                        end else begin
                            started_reg <= 1'b1;
                            pend_reg    <= 1'b0;
                            sym_reg     <= pend_reg ? '0 : code;
                            sym2_reg    <= code;
                            second_reg  <= pend_reg;
                        end
                    end else if (accept && in_cmd == CMD_END) begin
                        if (hv_reg) begin
                            ov_reg <= 1'b1;
                            od_reg <= {7'd0, hc_reg, hp_reg, he_reg, hs_reg};
                        end
                        cur_reg <= '0; pend_reg <= 1'b0; started_reg <= 1'b0;
                        pos_reg <= '0; hist_reg <= '0; hv_reg <= 1'b0;
                        hs_reg <= '0; he_reg <= '0; hp_reg <= '0; hc_reg <= '0;
                    end
                end
                ST_SYM_START: begin
                    // held match settles on the next symbol
                    if (hv_reg) begin
                        if (sym_reg == '0) begin
                            ov_reg <= 1'b1;
                            od_reg <= {7'd0, hc_reg, hp_reg, he_reg, hs_reg};
                        end
                        hv_reg <= 1'b0;
                    end
                    walk_reg  <= cur_reg;
                    steps_reg <= '0;
                end
                ST_GOTO_CHK: begin
                    if (walk_reg != '0 && t_rd == '0 &&
                            {19'd0, steps_reg} >= NODE_COUNT)
                        walk_reg <= '0;
                    else if (t_rd != '0)
                        walk_reg <= t_rd;
                end
                ST_FAIL_USE: begin
                    walk_reg  <= r_fail;
                    steps_reg <= steps_reg + 1'b1;
                end
                ST_NODE_WAIT: begin
                    cur_reg  <= walk_reg;
                    hist_reg <= {hist_reg[62:0], sym_reg == '0};
                    sat_reg  <= (pos_reg == '1);
                end
                ST_NODE_CHK: begin
                    if (!sat_reg) pos_reg <= pos_reg + 1'b1;
                    if (take) begin
                        hv_reg <= 1'b1;
                        hs_reg <= pos_reg + 32'd1 - {26'd0, r_len};
                        he_reg <= pos_reg + 32'd1;
                        hp_reg <= r_pid; hc_reg <= r_cat;
                    end
                end
                ST_OUT: begin
                    if (second_reg) begin
                        sym_reg    <= sym2_reg;
                        second_reg <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = od_reg;

`ifndef SYNTHESIS
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing |-> !s_tready) else $error("accept during clear");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid) else $error("result dropped");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_GOTO_WAIT) |-> !s_tready) else $error("ready in walk");
`endif
endmodule

// File: verif/multi_pattern_token_matcher_top_test.sv
module multi_pattern_token_matcher_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mptm_pkg::*;

    localparam int NODES    = 512;
    localparam int SLOTS    = 64;
    localparam int DRAIN    = 9000;   // drain time for the longest failure walk, two walks per byte
    localparam int ITEM_CAP = 800;

    // One reported match, match_start in the low bits as on m_tdata
    typedef struct packed {
        logic [7:0]  category;
        logic [8:0]  pattern;
        logic [31:0] stop;
        logic [31:0] start;
    } match_t;

    // Keeps its own copy of the tables and text walk, and queues the matches they predict
    class match_scoreboard;
        bit [8:0]  goto_tab [NODES*SLOTS];
        bit [8:0]  fail_of  [NODES];
        bit [8:0]  pat_of   [NODES];
        bit [7:0]  cat_of   [NODES];
        bit [5:0]  len_of   [NODES];
        bit [8:0]  cur;
        bit        space_pending, started, held_valid;
        bit [31:0] pos;
        bit [63:0] hist;
        match_t    held;
        match_t    pending [$];
        int        errors;
        int        match_count;

        function bit [5:0] sym_of(bit [7:0] b);
            if (b >= "A" && b <= "Z") return 6'(b - "A" + 1);
            if (b >= "a" && b <= "z") return 6'(b - "a" + 1);
            if (b >= "0" && b <= "9") return 6'(b - "0" + 27);
            case (b)
                "+": return 37;
                "#": return 38;
                ".": return 39;
                "&": return 40;
                "-": return 41;
                default: return 0;
            endcase
        endfunction

        function void clear_text();
            cur = 0; space_pending = 0; started = 0; pos = 0; hist = 0;
            held_valid = 0; held = '0;
        endfunction

        // One normalized symbol through the goto/fail walk
        function void feed(bit [5:0] sym);
            int steps;
            bit [8:0] node;
            bit sat;
            longint unsigned stop, len;
            steps = 0;
            node = cur;
            if (held_valid) begin
                if (sym == 0) pending = {pending, held};
                held_valid = 0;
            end
            while (node != 0 && goto_tab[node*SLOTS + sym] == 0) begin
                if (steps >= NODES) begin
                    node = 0;
                    break;
                end
                node = fail_of[node];
                steps++;
            end
            if (goto_tab[node*SLOTS + sym] != 0) node = goto_tab[node*SLOTS + sym];
            cur = node;
            hist = {hist[62:0], sym == 0};
            sat = (pos == 32'hFFFF_FFFF);
            stop = {32'd0, pos} + 64'd1;
            if (!sat) pos++;
            len = {58'd0, len_of[node]};
            if (sym != 0 && !sat && pat_of[node] != 0 && len <= 63) begin
                if (len == stop || (len < stop && hist[len])) begin
                    held_valid = 1;
                    held.start = 32'(stop - len);
                    held.stop = 32'(stop);
                    held.pattern = pat_of[node];
                    held.category = cat_of[node];
                end
            end
        endfunction

        function void note_request(logic [71:0] d);
            cmd_t cmd;
            bit [8:0] node, nxt, fl;
            bit [5:0] sym;
            cmd = cmd_t'(d[1:0]);
            node = d[10:2];
            sym = d[16:11];
            nxt = d[25:17];
            fl = d[34:26];
            case (cmd)
                CMD_LOAD_TRANS: goto_tab[node*SLOTS + sym] = nxt;
                CMD_LOAD_NODE: begin
                    fail_of[node] = fl;
                    pat_of[node] = d[43:35];
                    cat_of[node] = d[51:44];
                    len_of[node] = d[57:52];
                end
                CMD_TEXT: begin
                    sym = sym_of(d[65:58]);
                    if (sym == 0) begin
                        if (started) space_pending = 1;
                    end else begin
                        if (space_pending) begin
                            feed(0);
                            space_pending = 0;
                        end
                        feed(sym);
                        started = 1;
                    end
                end
                default: begin
                    if (held_valid) pending = {pending, held};
                    clear_text();
                end
            endcase
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(logic [87:0] d);
            match_t got, want;
            got = d[80:0];
            match_count++;
            if (pending.size() == 0) begin
                report($sformatf("unexpected match %h", got));
                return;
            end
            want = pending.pop_front();
            if (got.start !== want.start)
                report($sformatf("match_start %0d, want %0d", got.start, want.start));
            if (got.stop !== want.stop)
                report($sformatf("match_end %0d, want %0d", got.stop, want.stop));
            if (got.pattern !== want.pattern)
                report($sformatf("found_pattern %0d, want %0d", got.pattern, want.pattern));
            if (got.category !== want.category)
                report($sformatf("found_category %0d, want %0d", got.category, want.category));
            if (d[87:81] !== '0) report("nonzero fill bits on m_tdata");
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [87:0] m_tdata;

    match_scoreboard sb;
    int  sent;
    int  texts;
    bit  steady_src, steady_snk;

    // Trie built on the test side to produce a meaningful automaton
    int        trie_next [NODES][SLOTS];
    int        trie_depth [NODES];
    int        free_node;
    bit [5:0]  words [8][$];
    bit [5:0]  alphabet [6] = '{1, 2, 3, 27, 37, 39};

    multi_pattern_token_matcher_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial begin
        aclk = 0;
        forever #6 aclk = ~aclk;
    end

    // Gap length: mostly none or short, a few long
    function automatic int pick_gap(bit steady);
        int r;
        r = $urandom_range(99);
        if (steady || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [71:0] pack_req(cmd_t cmd, bit [8:0] node, bit [5:0] sym,
                                             bit [8:0] nxt, bit [8:0] fl, bit [8:0] pid,
                                             bit [7:0] cat, bit [5:0] len, bit [7:0] b);
        return {6'd0, b, len, cat, pid, fl, nxt, sym, node, cmd};
    endfunction

    // Send one request and log it once accepted
    task automatic send(logic [71:0] d);
        int gap;
        gap = pick_gap(steady_src);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        do @(posedge aclk); while (!s_tready);
        sb.note_request(d);
        sent++;
    endtask

    task automatic send_text_byte(bit [7:0] b);
        send(pack_req(CMD_TEXT, 9'($urandom), 6'($urandom), 9'($urandom), 9'($urandom),
                      9'($urandom), 8'($urandom), 6'($urandom), b));
    endtask

    task automatic send_end();
        send(pack_req(CMD_END, 9'($urandom), 6'($urandom), 9'($urandom), 9'($urandom),
                      9'($urandom), 8'($urandom), 6'($urandom), 8'($urandom)));
        texts++;
    endtask

    task automatic wait_idle();
        int n;
        s_tvalid <= 1'b0;
        n = 0;
        while (sb.pending.size() != 0 && n < 200000) begin
            @(posedge aclk);
            n++;
        end
        repeat (DRAIN) @(posedge aclk);
    endtask

    function automatic bit [7:0] byte_of(bit [5:0] sym);
        if (sym >= 1 && sym <= 26)
            return 8'(($urandom_range(1) ? "a" : "A") + sym - 1);
        if (sym >= 27 && sym <= 36) return 8'("0" + sym - 27);
        case (sym)
            37: return "+";
            38: return "#";
            39: return ".";
            40: return "&";
            41: return "-";
            default: return " ";
        endcase
    endfunction

    function automatic bit [7:0] separator_byte();
        case ($urandom_range(3))
            0: return " ";
            1: return ",";
            2: return 8'h0A;
            default: return 8'(8'h80 + $urandom_range(127));
        endcase
    endfunction

    // Load a fresh automaton of eight random words over a small alphabet
    task automatic load_automaton(bit wild_fails);
        int node, child, w, k;
        for (int i = 0; i < NODES; i++) begin
            trie_depth[i] = 0;
            for (int j = 0; j < SLOTS; j++) trie_next[i][j] = 0;
        end
        free_node = 1;
        for (w = 0; w < 8; w++) begin
            words[w].delete();
            k = $urandom_range(1, 4);
            repeat (k) words[w] = {words[w], alphabet[$urandom_range(5)]};
            node = 0;
            foreach (words[w][i]) begin
                child = trie_next[node][words[w][i]];
                if (child == 0) begin
                    child = free_node++;
                    trie_next[node][words[w][i]] = child;
                    trie_depth[child] = trie_depth[node] + 1;
                    send(pack_req(CMD_LOAD_TRANS, 9'(node), words[w][i], 9'(child),
                                  9'($urandom), 9'($urandom), 8'($urandom), 6'($urandom),
                                  8'($urandom)));
                end
                node = child;
            end
        end
        for (node = 1; node < free_node; node++) begin
            bit [8:0] fl, pid;
            bit [5:0] len;
            fl = 0;
            if (wild_fails || $urandom_range(3) == 0) fl = 9'($urandom_range(free_node - 1));
            pid = ($urandom_range(2) == 0) ? 9'd0 : 9'($urandom_range(1, 511));
            len = 6'(trie_depth[node]);
            if ($urandom_range(9) == 0) len = 6'($urandom_range(63));
            send(pack_req(CMD_LOAD_NODE, 9'(node), 6'($urandom), 9'($urandom), fl, pid,
                          8'($urandom), len, 8'($urandom)));
        end
    endtask

    // One text of words and separator runs, with a little noise
    task automatic send_random_text();
        int nwords;
        nwords = $urandom_range(1, 8);
        if ($urandom_range(3) == 0) send_text_byte(separator_byte());
        repeat (nwords) begin
            int w;
            w = $urandom_range(7);
            case ($urandom_range(9))
                0: send_text_byte(8'($urandom));
                1: repeat ($urandom_range(1, 3))
                       send_text_byte(byte_of(alphabet[$urandom_range(5)]));
                default: foreach (words[w][i]) send_text_byte(byte_of(words[w][i]));
            endcase
            repeat ($urandom_range(1, 2)) send_text_byte(separator_byte());
        end
        if ($urandom_range(1)) send_text_byte(byte_of(alphabet[$urandom_range(5)]));
        send_end();
    endtask

    // Result side: sample at the edge, then pick the next ready level
    initial begin
        int stall;
        m_tready = 1'b0;
        stall = 0;
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) sb.check_result(m_tdata);
            if (stall > 0) begin
                stall--;
                m_tready <= 1'b0;
            end else begin
                stall = pick_gap(steady_snk);
                m_tready <= (stall == 0);
            end
        end
    end

    initial begin
        #400ms;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        string words_in_text;
        sb = new();
        sb.clear_text();
        sent = 0;
        texts = 0;
        steady_src = 0;
        steady_snk = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: extremes of the load fields, unused symbol codes, separators at the edges
        steady_src = 1;
        send(pack_req(CMD_LOAD_TRANS, 511, 63, 511, '1, '1, '1, '1, '1));
        send(pack_req(CMD_LOAD_NODE, 511, '1, '1, 511, 511, 255, 63, '1));
        send(pack_req(CMD_LOAD_TRANS, 0, 1, 5, 0, 0, 0, 0, 0));        // root -a-> 5
        send(pack_req(CMD_LOAD_TRANS, 5, 27, 6, 0, 0, 0, 0, 0));       // 5 -0-> 6
        send(pack_req(CMD_LOAD_TRANS, 6, 41, 7, 0, 0, 0, 0, 0));       // 6 --> 7
        send(pack_req(CMD_LOAD_NODE, 5, 0, 0, 0, 1, 0, 1, 0));
        send(pack_req(CMD_LOAD_NODE, 6, 0, 0, 0, 511, 255, 2, 0));
        send(pack_req(CMD_LOAD_NODE, 7, 0, 0, 6, 3, 9, 40, 0));        // length longer than the text so far
        send(pack_req(CMD_LOAD_NODE, 8, 0, 0, 9, 4, 4, 1, 0));         // fail cycle 8 <-> 9
        send(pack_req(CMD_LOAD_NODE, 9, 0, 0, 8, 0, 0, 0, 0));
        send(pack_req(CMD_LOAD_TRANS, 5, 2, 8, 0, 0, 0, 0, 0));        // 5 -b-> 8
        words_in_text = "  A0 , a a0- ab b A0";
        foreach (words_in_text[i]) send_text_byte(words_in_text[i]);
        send_end();                                                    // match held at the end
        words_in_text = "a0 ab.b ";
        foreach (words_in_text[i]) send_text_byte(words_in_text[i]);
        send_end();
        send_end();                                                    // empty text
        wait_idle();

        // Random phases, each with a freshly loaded automaton
        for (int phase = 0; sent < ITEM_CAP; phase++) begin
            steady_src = (phase % 3 == 1);
            steady_snk = (phase % 4 == 2);
            load_automaton(phase % 5 == 3);
            repeat (6) begin
                send_random_text();
                if ($urandom_range(4) == 0)
                    send(pack_req(CMD_LOAD_NODE, 9'($urandom_range(1, free_node - 1)),
                                  6'($urandom), 9'($urandom), 0, 9'($urandom), 8'($urandom),
                                  6'($urandom_range(1, 4)), 8'($urandom)));
            end
            if (phase % 2 == 0) wait_idle();
        end
        wait_idle();

        $display("Run covered %0d requests in %0d texts with %0d matches reported.",
                 sent, texts, sb.match_count);
        if (sb.pending.size() != 0) sb.report($sformatf("%0d matches never reported",
                                                         sb.pending.size()));
        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/mptm_pkg.sv
rtl/mptm_ram.sv
rtl/multi_pattern_token_matcher_top.sv
verif/multi_pattern_token_matcher_top_test.sv
